// ===== sv/vertex_rotate_project_defines.svh =====
// ----------------------------------------------------------------------------
// Vertex rotate and project: assertion macros
// Shared concurrent-check macros, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

// same-cycle implication
`define VRP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// Vertex rotate and project: package
// Fixed-point constants, register indexes and rounding helpers.
// ----------------------------------------------------------------------------
package vrp_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DIV_STEPS  = 4;                 // quotient bits per divider stage
	localparam int DIV_STAGES = 32 / DIV_STEPS;
	localparam int DIV_LAT    = DIV_STAGES + 2;    // entry + iterations + output
	localparam int FRONT_LAT  = 7;
	localparam int TOTAL_LAT  = FRONT_LAT + DIV_LAT;

	localparam logic [2:0] REG_COS       = 3'd0;
	localparam logic [2:0] REG_SIN       = 3'd1;
	localparam logic [2:0] REG_XSCALE    = 3'd2;
	localparam logic [2:0] REG_YSCALE    = 3'd3;
	localparam logic [2:0] REG_DSCALE    = 3'd4;
	localparam logic [2:0] REG_DOFFSET   = 3'd5;
	localparam logic [2:0] REG_ZSHIFT    = 3'd6;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// round half up to FRAC_BITS fraction bits, then saturate
	function automatic logic signed [31:0] round_sat(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + (64'sd1 <<< (FRAC_BITS - 1));
		return sat32(t >>> FRAC_BITS);
	endfunction

endpackage

// ===== sv/vrp_div.sv =====
// ----------------------------------------------------------------------------
// Vertex rotate and project: pipelined divider
// Signed 64 by 32 division truncated toward zero, saturated to 32 bits,
// DIV_STEPS restoring steps per stage. A zero divisor passes the rounded
// numerator instead.
// ----------------------------------------------------------------------------
module vrp_div (
	input  logic               clk,
	input  logic signed [63:0] num,
	input  logic signed [31:0] den,
	output logic signed [31:0] quot
);

	typedef struct packed {
		logic        neg;
		logic        ovf;
		logic        zero;
		logic [31:0] byp;
		logic [31:0] ad;
		logic [63:0] pr;   // remainder above, dividend bits then quotient below
	} div_stage_t;

	div_stage_t stg_s [vrp_pkg::DIV_STAGES + 1];
	div_stage_t entry;
	logic [63:0] an;

	always_comb begin
		an         = num[63] ? 64'(-num) : 64'(num);
		entry.neg  = num[63] ^ den[31];
		entry.zero = (den == 32'sd0);
		entry.ad   = den[31] ? 32'(-den) : 32'(den);
		entry.ovf  = an[63:32] >= entry.ad;
		entry.byp  = vrp_pkg::round_sat(num);
		entry.pr   = an;
	end

	always_ff @(posedge clk) begin
		stg_s[0] <= entry;
	end

	for (genvar g = 0; g < vrp_pkg::DIV_STAGES; g++) begin : g_stage
		div_stage_t nxt;
		always_comb begin
			logic [32:0] t;
			nxt = stg_s[g];
			for (int k = 0; k < vrp_pkg::DIV_STEPS; k++) begin
				t = {nxt.pr[63:32], nxt.pr[31]};
				if (t >= {1'b0, nxt.ad}) begin
					t = t - {1'b0, nxt.ad};
					nxt.pr = {t[31:0], nxt.pr[30:0], 1'b1};
				end else begin
					nxt.pr = {t[31:0], nxt.pr[30:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			stg_s[g + 1] <= nxt;
		end
	end

	div_stage_t last;
	logic [31:0] q;
	logic signed [31:0] res;

	always_comb begin
		last = stg_s[vrp_pkg::DIV_STAGES];
		q    = last.pr[31:0];
		if (last.zero)
			res = last.byp;
		else if (last.neg)
			res = (last.ovf || q > 32'h8000_0000) ? 32'sh8000_0000 : 32'(-q);
		else
			res = (last.ovf || q[31]) ? 32'sh7FFF_FFFF : q;
	end

	always_ff @(posedge clk) begin
		quot <= res;
	end

endmodule

// ===== sv/vertex_rotate_project.sv =====
// ----------------------------------------------------------------------------
// Vertex rotate and project
// Rotates a Q15.16 vertex about Z then X, shifts z, projects and divides by w.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write cfg_wdata to register cfg_idx while cfg_we is high;
//   only while no vertex is in flight. Unknown indexes are ignored.
//   Input: a vertex request is taken on each edge with start high and busy
//   low. busy stays low, so one vertex may enter every cycle.
//   Output: done pulses for one cycle with proj_x, proj_y, proj_z and
//   w_is_zero; the receiver cannot stall, so nothing is ever held back.
//   Pipeline: accept to done runs through seven arithmetic stages of
//   rotation, translation and projection, then the divider: one entry stage,
//   eight stages of four quotient bits, one saturation stage.
//   Throughput: one vertex per cycle, set by the fully pipelined divider.
//   Reset: arst_n clears the pipeline valid bits and loads the default
//   angle, scales, depth terms and z shift.
// ----------------------------------------------------------------------------
`include "vertex_rotate_project_defines.svh"

module vertex_rotate_project (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] vert_x,
	input  logic signed [31:0] vert_y,
	input  logic signed [31:0] vert_z,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	output logic               done,
	output logic signed [31:0] proj_x,
	output logic signed [31:0] proj_y,
	output logic signed [31:0] proj_z,
	output logic               w_is_zero
);

	logic signed [17:0] cos_q, sin_q;
	logic [30:0]        xscale_q, yscale_q;
	logic signed [31:0] dscale_q, doffset_q, zshift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q     <= 18'sd65536;
			sin_q     <= 18'sd0;
			xscale_q  <= 31'd104858;
			yscale_q  <= 31'd65536;
			dscale_q  <= 32'sd65601;
			doffset_q <= -32'sd6560;
			zshift_q  <= 32'sd196608;
		end else if (cfg_we) begin
			case (cfg_idx)
				vrp_pkg::REG_COS:     cos_q     <= cfg_wdata[17:0];
				vrp_pkg::REG_SIN:     sin_q     <= cfg_wdata[17:0];
				vrp_pkg::REG_XSCALE:  xscale_q  <= cfg_wdata[30:0];
				vrp_pkg::REG_YSCALE:  yscale_q  <= cfg_wdata[30:0];
				vrp_pkg::REG_DSCALE:  dscale_q  <= cfg_wdata;
				vrp_pkg::REG_DOFFSET: doffset_q <= cfg_wdata;
				vrp_pkg::REG_ZSHIFT:  zshift_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// valid line: front stages then divider
	logic [vrp_pkg::TOTAL_LAT-1:0] vld_q;
	logic [vrp_pkg::DIV_LAT-1:0]   wz_q;

	// stage 1: first rotation products
	logic signed [49:0] xc_s1, ys_s1, xs_s1, yc_s1;
	logic signed [31:0] z_s1;
	// stage 2: rotated about Z
	logic signed [31:0] x1_s2, y1_s2, z_s2;
	// stage 3: second rotation products
	logic signed [49:0] yc_s3, zs_s3, ys_s3, zc_s3;
	logic signed [31:0] x1_s3;
	// stage 4: rotated about X
	logic signed [31:0] x1_s4, y2_s4, z2_s4;
	// stage 5: translated
	logic signed [31:0] x1_s5, y2_s5, w_s5;
	// stage 6: projection products
	logic signed [63:0] nx_s6, ny_s6, wd_s6;
	logic signed [31:0] w_s6;
	// stage 7: numerators
	logic signed [63:0] nx_s7, ny_s7, nz_s7;
	logic signed [31:0] w_s7;

	always_ff @(posedge clk) begin
		xc_s1 <= 50'(vert_x * cos_q);
		ys_s1 <= 50'(vert_y * sin_q);
		xs_s1 <= 50'(vert_x * sin_q);
		yc_s1 <= 50'(vert_y * cos_q);
		z_s1  <= vert_z;

		x1_s2 <= vrp_pkg::round_sat(64'(xc_s1) - 64'(ys_s1));
		y1_s2 <= vrp_pkg::round_sat(64'(xs_s1) + 64'(yc_s1));
		z_s2  <= z_s1;

		yc_s3 <= 50'(y1_s2 * cos_q);
		zs_s3 <= 50'(z_s2 * sin_q);
		ys_s3 <= 50'(y1_s2 * sin_q);
		zc_s3 <= 50'(z_s2 * cos_q);
		x1_s3 <= x1_s2;

		x1_s4 <= x1_s3;
		y2_s4 <= vrp_pkg::round_sat(64'(yc_s3) - 64'(zs_s3));
		z2_s4 <= vrp_pkg::round_sat(64'(ys_s3) + 64'(zc_s3));

		x1_s5 <= x1_s4;
		y2_s5 <= y2_s4;
		w_s5  <= vrp_pkg::sat32(64'(z2_s4) + 64'(zshift_q));

		nx_s6 <= 64'(x1_s5) * 64'(signed'({1'b0, xscale_q}));
		ny_s6 <= 64'(y2_s5) * 64'(signed'({1'b0, yscale_q}));
		wd_s6 <= 64'(w_s5) * 64'(dscale_q);
		w_s6  <= w_s5;

		nx_s7 <= nx_s6;
		ny_s7 <= ny_s6;
		nz_s7 <= wd_s6 + (64'(doffset_q) <<< vrp_pkg::FRAC_BITS);
		w_s7  <= w_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[vrp_pkg::TOTAL_LAT-2:0], accept};
		end
	end

	// zero-w flag travels beside the divider
	always_ff @(posedge clk) begin
		wz_q <= {wz_q[vrp_pkg::DIV_LAT-2:0], (w_s7 == 32'sd0)};
	end

	vrp_div u_div_x (.clk(clk), .num(nx_s7), .den(w_s7), .quot(proj_x));
	vrp_div u_div_y (.clk(clk), .num(ny_s7), .den(w_s7), .quot(proj_y));
	vrp_div u_div_z (.clk(clk), .num(nz_s7), .den(w_s7), .quot(proj_z));

	assign done      = vld_q[vrp_pkg::TOTAL_LAT-1];
	assign w_is_zero = wz_q[vrp_pkg::DIV_LAT-1];

	`VRP_ASSERT_NOW(a_done_from_accept, done, $past(accept, vrp_pkg::TOTAL_LAT), "result without request")
	`VRP_ASSERT_NOW(a_done_from_front, done, $past(vld_q[vrp_pkg::FRONT_LAT-1], vrp_pkg::DIV_LAT), "divider valid slip")
	`VRP_ASSERT_NEXT(a_wzero_next, vld_q[vrp_pkg::TOTAL_LAT-2] && wz_q[vrp_pkg::DIV_LAT-2], done && w_is_zero, "zero-w flag lost")

endmodule
